### rtl/rfde_pkg.sv
// ----------------------------------------------------------------------------
// rfde_pkg
// Shared types and constants of the rotated frame buffer draw engine.
// ----------------------------------------------------------------------------
package rfde_pkg;

	localparam int CANVAS_WIDTH_DEF  = 256;
	localparam int CANVAS_HEIGHT_DEF = 128;

	localparam int OP_W    = 3;
	localparam int XY_W    = 16;
	localparam int PIX_W   = 16;
	localparam int ROT_W   = 2;
	localparam int COORD_W = 18;

	localparam logic [OP_W-1:0] OP_PLOT  = 3'd0;
	localparam logic [OP_W-1:0] OP_RDROT = 3'd1;
	localparam logic [OP_W-1:0] OP_RDRAW = 3'd2;
	localparam logic [OP_W-1:0] OP_HLINE = 3'd3;
	localparam logic [OP_W-1:0] OP_VLINE = 3'd4;
	localparam logic [OP_W-1:0] OP_FILL  = 3'd5;
	localparam logic [OP_W-1:0] OP_SWAP  = 3'd6;
	localparam logic [OP_W-1:0] OP_NOP   = 3'd7;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_PREP,
		ST_CLIP,
		ST_MAP,
		ST_MUL,
		ST_WALK,
		ST_READ,
		ST_SWEEP,
		ST_DRAIN,
		ST_DONE
	} state_t;

endpackage

### rtl/rfde_ifs.sv
// ----------------------------------------------------------------------------
// rfde channel interfaces
// Command, result and configuration channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
interface rfde_cmd_if;
	logic                                valid;
	logic                                ready;
	logic        [rfde_pkg::OP_W-1:0]   op;
	logic signed [rfde_pkg::XY_W-1:0]   pos_x;
	logic signed [rfde_pkg::XY_W-1:0]   pos_y;
	logic signed [rfde_pkg::XY_W-1:0]   length;
	logic        [rfde_pkg::PIX_W-1:0]  color;
	modport source (output valid, op, pos_x, pos_y, length, color, input ready);
	modport sink (input valid, op, pos_x, pos_y, length, color, output ready);
endinterface

interface rfde_res_if;
	logic                             valid;
	logic                             ready;
	logic [rfde_pkg::PIX_W-1:0]       pixel_value;
	modport source (output valid, pixel_value, input ready);
	modport sink (input valid, pixel_value, output ready);
endinterface

interface rfde_cfg_if;
	logic                             valid;
	logic                             ready;
	logic [rfde_pkg::ROT_W-1:0]       rotation;
	modport source (output valid, rotation, input ready);
	modport sink (input valid, rotation, output ready);
endinterface

### rtl/rotated_framebuffer_draw_engine.sv
// ----------------------------------------------------------------------------
// rotated_framebuffer_draw_engine
// RGB565 frame store with plot, read, clipped line, fill and byte swap
// commands, seen through a programmable quarter-turn rotation.
// ----------------------------------------------------------------------------
// Channel  Dir  Word
// cmd      in   op, pos_x, pos_y, length, color
// res      out  pixel_value
// cfg      in   rotation
//
// Plot, read and line commands pass prepare, clip, map and address states,
// then a read reads the store and a plot or line writes its clipped pixels;
// off canvas they skip to the result, as a no-op does. Fill and byte swap make
// one store port pass each. After reset a clearing pass zeroes the store and
// cmd.ready is low; cmd.ready is high only between commands. A result waits
// in the output register while the next word is accepted. cfg is always ready.
// ----------------------------------------------------------------------------
module rotated_framebuffer_draw_engine #(
	parameter int CANVAS_WIDTH  = rfde_pkg::CANVAS_WIDTH_DEF,
	parameter int CANVAS_HEIGHT = rfde_pkg::CANVAS_HEIGHT_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	rfde_cmd_if.sink   cmd,
	rfde_res_if.source res,
	rfde_cfg_if.sink   cfg
);

	localparam int SIZE  = CANVAS_WIDTH * CANVAS_HEIGHT;
	localparam int AW    = (SIZE > 1) ? $clog2(SIZE) : 1;
	localparam int MAXD  = (CANVAS_WIDTH > CANVAS_HEIGHT) ? CANVAS_WIDTH : CANVAS_HEIGHT;
	localparam int CRD_W = (MAXD > 1) ? $clog2(MAXD) : 1;
	localparam int CW    = rfde_pkg::COORD_W;
	localparam int XW    = rfde_pkg::XY_W;
	localparam int PW    = rfde_pkg::PIX_W;

	localparam logic [AW-1:0] LAST   = AW'(SIZE - 1);
	localparam logic [AW-1:0] ONE    = AW'(1);
	localparam logic [AW-1:0] W_STEP = AW'(CANVAS_WIDTH);
	localparam logic [CRD_W-1:0] WM1 = CRD_W'(CANVAS_WIDTH - 1);
	localparam logic [CRD_W-1:0] HM1 = CRD_W'(CANVAS_HEIGHT - 1);
	localparam logic signed [CW-1:0] LIM_W = CW'(CANVAS_WIDTH);
	localparam logic signed [CW-1:0] LIM_H = CW'(CANVAS_HEIGHT);

	rfde_pkg::state_t st_q, st_d;

	logic [PW-1:0] mem [SIZE];
	logic [PW-1:0] rdata_q;
	logic          we;
	logic [AW-1:0] waddr, raddr;
	logic [PW-1:0] wdata;

	logic [rfde_pkg::OP_W-1:0]  op_q;
	logic signed [XW-1:0]       x_q, y_q, len_q, across_q;
	logic [PW-1:0]              color_q, res_q, res_data_q;
	logic                       res_valid_q;
	logic [rfde_pkg::ROT_W-1:0] rot_q, rot_eff_q;
	logic                       horiz_q, across_ok_q;
	logic signed [CW-1:0]       start_q, end_q, lim_along_q, k_q;
	logic [CRD_W-1:0]           rx_q, ry_q;
	logic [AW-1:0]              addr_q, i_q, ad_s1;
	logic                       rd_v_s1;

	logic                       horiz, is_line, is_read, hit, last_px;
	logic signed [XW-1:0]       along, acr, leng;
	logic signed [CW-1:0]       along_e, leng_e, start_c, end_c, lim_across, k_nx;
	logic signed [CW-1:0]       lw, lh;
	logic [rfde_pkg::ROT_W-1:0] rot_eff;
	logic [CRD_W-1:0]           lx, ly, rx, ry;
	logic [AW-1:0]              step;
	logic [PW-1:0]              swapped;

	assign cmd.ready       = (st_q == rfde_pkg::ST_IDLE);
	assign cfg.ready       = 1'b1;
	assign res.valid       = res_valid_q;
	assign res.pixel_value = res_data_q;

	assign horiz      = (op_q != rfde_pkg::OP_VLINE);
	assign is_line    = (op_q == rfde_pkg::OP_HLINE) || (op_q == rfde_pkg::OP_VLINE);
	assign is_read    = (op_q == rfde_pkg::OP_RDROT) || (op_q == rfde_pkg::OP_RDRAW);
	assign along      = horiz ? x_q : y_q;
	assign acr        = horiz ? y_q : x_q;
	assign leng       = is_line ? len_q : XW'(1);
	assign along_e    = CW'(along);
	assign leng_e     = CW'(leng);
	assign rot_eff    = (op_q == rfde_pkg::OP_RDRAW) ? '0 : rot_q;
	assign lw         = rot_eff[0] ? LIM_H : LIM_W;
	assign lh         = rot_eff[0] ? LIM_W : LIM_H;
	assign lim_across = horiz ? lh : lw;
	assign start_c    = start_q[CW-1] ? '0 : start_q;
	assign end_c      = (end_q > lim_along_q) ? lim_along_q : end_q;
	assign hit        = across_ok_q && (start_q < end_q);
	assign k_nx       = k_q + CW'(1);
	assign last_px    = !(k_nx < end_q);
	assign swapped    = {rdata_q[7:0], rdata_q[15:8]};

	assign lx = horiz_q ? CRD_W'(start_q) : CRD_W'(across_q);
	assign ly = horiz_q ? CRD_W'(across_q) : CRD_W'(start_q);

	always_comb begin
		case (rot_eff_q)
			2'd1: begin
				rx = WM1 - ly;
				ry = lx;
			end
			2'd2: begin
				rx = WM1 - lx;
				ry = HM1 - ly;
			end
			2'd3: begin
				rx = ly;
				ry = HM1 - lx;
			end
			default: begin
				rx = lx;
				ry = ly;
			end
		endcase
	end

	always_comb begin
		case ({horiz_q, rot_eff_q})
			3'b100: step = ONE;
			3'b101: step = W_STEP;
			3'b110: step = '0 - ONE;
			3'b111: step = '0 - W_STEP;
			3'b000: step = W_STEP;
			3'b001: step = '0 - ONE;
			3'b010: step = '0 - W_STEP;
			default: step = ONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= rfde_pkg::ST_CLEAR;
		end else begin
			st_q <= st_d;
		end
	end

	always_comb begin
		st_d  = st_q;
		we    = 1'b0;
		waddr = i_q;
		wdata = '0;
		raddr = i_q;
		case (st_q)
			rfde_pkg::ST_CLEAR: begin
				we = 1'b1;
				if (i_q == LAST) begin
					st_d = rfde_pkg::ST_IDLE;
				end
			end
			rfde_pkg::ST_IDLE: begin
				if (cmd.valid) begin
					st_d = rfde_pkg::ST_PREP;
				end
			end
			rfde_pkg::ST_PREP: begin
				if (op_q == rfde_pkg::OP_FILL || op_q == rfde_pkg::OP_SWAP) begin
					st_d = rfde_pkg::ST_SWEEP;
				end else if (op_q == rfde_pkg::OP_NOP) begin
					st_d = rfde_pkg::ST_DONE;
				end else begin
					st_d = rfde_pkg::ST_CLIP;
				end
			end
			rfde_pkg::ST_CLIP: st_d = rfde_pkg::ST_MAP;
			rfde_pkg::ST_MAP: st_d = hit ? rfde_pkg::ST_MUL : rfde_pkg::ST_DONE;
			rfde_pkg::ST_MUL: st_d = rfde_pkg::ST_WALK;
			rfde_pkg::ST_WALK: begin
				raddr = addr_q;
				if (is_read) begin
					st_d = rfde_pkg::ST_READ;
				end else begin
					we    = 1'b1;
					waddr = addr_q;
					wdata = color_q;
					if (last_px) begin
						st_d = rfde_pkg::ST_DONE;
					end
				end
			end
			rfde_pkg::ST_READ: st_d = rfde_pkg::ST_DONE;
			rfde_pkg::ST_SWEEP: begin
				if (op_q == rfde_pkg::OP_FILL) begin
					we    = 1'b1;
					wdata = color_q;
				end else if (rd_v_s1) begin
					we    = 1'b1;
					waddr = ad_s1;
					wdata = swapped;
				end
				if (i_q == LAST) begin
					st_d = (op_q == rfde_pkg::OP_SWAP) ? rfde_pkg::ST_DRAIN
						: rfde_pkg::ST_DONE;
				end
			end
			rfde_pkg::ST_DRAIN: begin
				we    = 1'b1;
				waddr = ad_s1;
				wdata = swapped;
				st_d  = rfde_pkg::ST_DONE;
			end
			rfde_pkg::ST_DONE: begin
				if (!res_valid_q || res.ready) begin
					st_d = rfde_pkg::ST_IDLE;
				end
			end
			default: st_d = rfde_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rot_q       <= '0;
			i_q         <= '0;
			rd_v_s1     <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (cfg.valid) begin
				rot_q <= cfg.rotation;
			end
			case (st_q)
				rfde_pkg::ST_CLEAR: i_q <= i_q + ONE;
				rfde_pkg::ST_PREP: begin
					i_q     <= '0;
					rd_v_s1 <= 1'b0;
				end
				rfde_pkg::ST_SWEEP: begin
					i_q     <= i_q + ONE;
					rd_v_s1 <= (op_q == rfde_pkg::OP_SWAP);
				end
				default: begin
				end
			endcase
			if (st_q == rfde_pkg::ST_DONE && (!res_valid_q || res.ready)) begin
				res_valid_q <= 1'b1;
			end else if (res.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (st_q)
			rfde_pkg::ST_IDLE: begin
				op_q    <= cmd.op;
				x_q     <= cmd.pos_x;
				y_q     <= cmd.pos_y;
				len_q   <= cmd.length;
				color_q <= cmd.color;
			end
			rfde_pkg::ST_PREP: begin
				res_q       <= '0;
				horiz_q     <= horiz;
				rot_eff_q   <= rot_eff;
				across_q    <= acr;
				across_ok_q <= !acr[XW-1] && (CW'(acr) < lim_across);
				lim_along_q <= horiz ? lw : lh;
				if (leng[XW-1]) begin
					start_q <= along_e + leng_e + CW'(1);
					end_q   <= along_e + CW'(1);
				end else begin
					start_q <= along_e;
					end_q   <= along_e + leng_e;
				end
			end
			rfde_pkg::ST_CLIP: begin
				start_q <= start_c;
				end_q   <= end_c;
			end
			rfde_pkg::ST_MAP: begin
				rx_q <= rx;
				ry_q <= ry;
				k_q  <= start_q;
			end
			rfde_pkg::ST_MUL: addr_q <= AW'(ry_q) * W_STEP + AW'(rx_q);
			rfde_pkg::ST_WALK: begin
				k_q    <= k_nx;
				addr_q <= addr_q + step;
			end
			rfde_pkg::ST_READ: res_q <= rdata_q;
			rfde_pkg::ST_SWEEP: ad_s1 <= i_q;
			rfde_pkg::ST_DONE: begin
				if (!res_valid_q || res.ready) begin
					res_data_q <= res_q;
				end
			end
			default: begin
			end
		endcase
	end

	a_done_loads: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == rfde_pkg::ST_DONE && (!res_valid_q || res.ready)) |=> res_valid_q)
		else $error("finished command did not load the result register");

	a_write_in_store: assert property (@(posedge clk) disable iff (!arst_n)
		we |-> (waddr <= LAST))
		else $error("frame store write outside the canvas");

	a_no_cmd_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == rfde_pkg::ST_CLEAR) |-> !cmd.ready)
		else $error("command accepted during the clearing pass");

	a_walk_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == rfde_pkg::ST_WALK) |-> (!k_q[CW-1] && (k_q < lim_along_q)))
		else $error("line walk left the logical canvas");

endmodule
